FILE: hw/rtl/helmert_four_param_fit_top_assert.svh
// Assertion macros shared by the checker of the Helmert fit block.
`ifndef HELMERT_FOUR_PARAM_FIT_TOP_ASSERT_SVH
`define HELMERT_FOUR_PARAM_FIT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("helmert fit check failed");

// Consequent must hold in the cycle after the antecedent.
`define HFIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("helmert fit check failed");

`endif

FILE: hw/rtl/hfit_pkg.sv
// Types, constants and the solve microcode of the Helmert fit block.
package hfit_pkg;

  localparam int WW    = 192;
  localparam int CW    = 36;
  localparam int DW    = 32;
  localparam int SW    = 64;
  localparam int NSUMS = 7;
  localparam int OFFW  = 40;
  localparam int SCW   = 43;
  localparam logic signed [CW:0] DIFF_LIMIT = 37'sd2147483647;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef logic [NSUMS-1:0][SW-1:0] sum_arr_t;
  typedef logic [3:0][CW-1:0] pair_t;

  typedef struct packed {
    logic done;
    logic range_err;
  } acc_stat_t;

  typedef enum logic [1:0] {K_MAC, K_CHK, K_DIV, K_END} kind_t;
  typedef enum logic [2:0] {A_N, A_SSU, A_SSV, A_D, A_NC, A_ND, A_TMP, A_NDN} asel_t;
  typedef enum logic [3:0] {
    B_N, B_SSU, B_SSV, B_SSQ, B_STU, B_STV, B_SP, B_SQ,
    B_OX, B_OY, B_OTX, B_OTY, B_SCALE
  } bsel_t;
  typedef enum logic [2:0] {DST_NONE, DST_D, DST_NC, DST_ND, DST_NDN, DST_TMP, DST_T} dst_t;
  typedef enum logic {DEN_NDN, DEN_D} den_t;
  typedef enum logic [1:0] {R_OX, R_OY, R_SC, R_SS} res_t;

  typedef struct packed {
    kind_t kind;
    asel_t a;
    bsel_t b;
    logic  sub;
    logic  first;
    dst_t  dst;
    den_t  den;
    res_t  res;
  } uop_t;

  function automatic uop_t mac(input asel_t a, input bsel_t b, input logic sub,
                               input logic first, input dst_t dst);
    uop_t u;
    u = '{kind: K_MAC, a: a, b: b, sub: sub, first: first, dst: dst,
          den: DEN_D, res: R_OX};
    return u;
  endfunction

  function automatic uop_t dvd(input den_t den, input res_t res);
    uop_t u;
    u = '{kind: K_DIV, a: A_N, b: B_N, sub: 1'b0, first: 1'b0, dst: DST_NONE,
          den: den, res: res};
    return u;
  endfunction

  function automatic uop_t ucode(input logic [4:0] step);
    uop_t u;
    u = '{kind: K_END, a: A_N, b: B_N, sub: 1'b0, first: 1'b0, dst: DST_NONE,
          den: DEN_D, res: R_OX};
    unique case (step)
      5'd0:  u = mac(A_N,   B_SSQ,   1'b0, 1'b1, DST_NONE);
      5'd1:  u = mac(A_SSU, B_SSU,   1'b1, 1'b0, DST_NONE);
      5'd2:  u = mac(A_SSV, B_SSV,   1'b1, 1'b0, DST_D);
      5'd3:  u.kind = K_CHK;
      5'd4:  u = mac(A_N,   B_SP,    1'b0, 1'b1, DST_NONE);
      5'd5:  u = mac(A_SSU, B_STU,   1'b1, 1'b0, DST_NONE);
      5'd6:  u = mac(A_SSV, B_STV,   1'b1, 1'b0, DST_NC);
      5'd7:  u = mac(A_N,   B_SQ,    1'b0, 1'b1, DST_NONE);
      5'd8:  u = mac(A_SSU, B_STV,   1'b1, 1'b0, DST_NONE);
      5'd9:  u = mac(A_SSV, B_STU,   1'b0, 1'b0, DST_ND);
      5'd10: u = mac(A_D,   B_N,     1'b0, 1'b1, DST_NDN);
      5'd11: u = mac(A_NC,  B_OX,    1'b0, 1'b1, DST_NONE);
      5'd12: u = mac(A_ND,  B_OY,    1'b1, 1'b0, DST_TMP);
      5'd13: u = mac(A_D,   B_STU,   1'b0, 1'b1, DST_NONE);
      5'd14: u = mac(A_NC,  B_SSU,   1'b1, 1'b0, DST_NONE);
      5'd15: u = mac(A_ND,  B_SSV,   1'b0, 1'b0, DST_NONE);
      5'd16: u = mac(A_TMP, B_N,     1'b1, 1'b0, DST_NONE);
      5'd17: u = mac(A_NDN, B_OTX,   1'b0, 1'b0, DST_T);
      5'd18: u = dvd(DEN_NDN, R_OX);
      5'd19: u = mac(A_ND,  B_OX,    1'b0, 1'b1, DST_NONE);
      5'd20: u = mac(A_NC,  B_OY,    1'b0, 1'b0, DST_TMP);
      5'd21: u = mac(A_D,   B_STV,   1'b0, 1'b1, DST_NONE);
      5'd22: u = mac(A_ND,  B_SSU,   1'b1, 1'b0, DST_NONE);
      5'd23: u = mac(A_NC,  B_SSV,   1'b1, 1'b0, DST_NONE);
      5'd24: u = mac(A_TMP, B_N,     1'b1, 1'b0, DST_NONE);
      5'd25: u = mac(A_NDN, B_OTY,   1'b0, 1'b0, DST_T);
      5'd26: u = dvd(DEN_NDN, R_OY);
      5'd27: u = mac(A_NC,  B_SCALE, 1'b0, 1'b1, DST_T);
      5'd28: u = dvd(DEN_D, R_SC);
      5'd29: u = mac(A_ND,  B_SCALE, 1'b0, 1'b1, DST_T);
      5'd30: u = dvd(DEN_D, R_SS);
      default: u.kind = K_END;
    endcase
    return u;
  endfunction

endpackage

FILE: hw/rtl/hfit_accum.sv
// Normal-equation accumulator with one shared 32 by 32 multiplier.
module hfit_accum #(
  parameter int MAX_PAIRS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          clear,
  input  hfit_pkg::pair_t               pair,
  output hfit_pkg::acc_stat_t           stat,
  output logic [$clog2(MAX_PAIRS+1)-1:0] pair_count,
  output hfit_pkg::sum_arr_t            sums,
  output hfit_pkg::pair_t               origin
);

  localparam int CNTW = $clog2(MAX_PAIRS + 1);

  typedef enum logic [1:0] {A_IDLE, A_DIFF, A_MUL, A_ADD} astate_t;

  astate_t state;
  hfit_pkg::pair_t p;
  logic [3:0][hfit_pkg::DW-1:0] d;
  logic [5:0][hfit_pkg::SW-1:0] prod;
  logic [2:0] mcnt;
  logic rerr;
  logic done;

  logic signed [hfit_pkg::CW:0] diff [4];
  logic bad_diff;
  logic signed [hfit_pkg::DW-1:0] mul_a, mul_b;
  logic [hfit_pkg::NSUMS-1:0][hfit_pkg::SW-1:0] addend;
  logic [hfit_pkg::NSUMS-1:0][hfit_pkg::SW:0] sum_next;
  logic ovf;

  assign stat.done = done;
  assign stat.range_err = rerr;

  always_comb begin
    bad_diff = 1'b0;
    for (int i = 0; i < 4; i++) begin
      diff[i] = $signed({p[i][hfit_pkg::CW-1], p[i]})
              - $signed({origin[i][hfit_pkg::CW-1], origin[i]});
      if (diff[i] > hfit_pkg::DIFF_LIMIT || diff[i] < -hfit_pkg::DIFF_LIMIT) begin
        bad_diff = 1'b1;
      end
    end
  end

  always_comb begin
    case (mcnt)
      3'd0: begin mul_a = d[0]; mul_b = d[0]; end
      3'd1: begin mul_a = d[1]; mul_b = d[1]; end
      3'd2: begin mul_a = d[0]; mul_b = d[2]; end
      3'd3: begin mul_a = d[1]; mul_b = d[3]; end
      3'd4: begin mul_a = d[0]; mul_b = d[3]; end
      3'd5: begin mul_a = d[1]; mul_b = d[2]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    addend[0] = {{(hfit_pkg::SW-hfit_pkg::DW){d[0][hfit_pkg::DW-1]}}, d[0]};
    addend[1] = {{(hfit_pkg::SW-hfit_pkg::DW){d[1][hfit_pkg::DW-1]}}, d[1]};
    addend[2] = prod[0] + prod[1];
    addend[3] = {{(hfit_pkg::SW-hfit_pkg::DW){d[2][hfit_pkg::DW-1]}}, d[2]};
    addend[4] = {{(hfit_pkg::SW-hfit_pkg::DW){d[3][hfit_pkg::DW-1]}}, d[3]};
    addend[5] = prod[2] + prod[3];
    addend[6] = prod[4] - prod[5];
    ovf = 1'b0;
    for (int i = 0; i < hfit_pkg::NSUMS; i++) begin
      sum_next[i] = {sums[i][hfit_pkg::SW-1], sums[i]}
                  + {addend[i][hfit_pkg::SW-1], addend[i]};
      if (sum_next[i][hfit_pkg::SW] != sum_next[i][hfit_pkg::SW-1]) begin
        ovf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      pair_count <= '0;
      rerr <= 1'b0;
      done <= 1'b0;
      sums <= '0;
      mcnt <= '0;
    end else begin
      done <= 1'b0;
      if (clear) begin
        pair_count <= '0;
        rerr <= 1'b0;
        sums <= '0;
      end
      unique case (state)
        A_IDLE: begin
          if (start) begin
            p <= pair;
            if (pair_count >= CNTW'(MAX_PAIRS)) begin
              rerr <= 1'b1;
              done <= 1'b1;
            end else begin
              if (pair_count == '0) begin
                origin <= pair;
              end
              pair_count <= pair_count + 1'b1;
              if (rerr) begin
                done <= 1'b1;
              end else begin
                state <= A_DIFF;
              end
            end
          end
        end
        A_DIFF: begin
          if (bad_diff) begin
            rerr <= 1'b1;
            done <= 1'b1;
            state <= A_IDLE;
          end else begin
            for (int i = 0; i < 4; i++) begin
              d[i] <= diff[i][hfit_pkg::DW-1:0];
            end
            mcnt <= '0;
            state <= A_MUL;
          end
        end
        A_MUL: begin
          prod[mcnt] <= hfit_pkg::SW'(mul_a * mul_b);
          mcnt <= mcnt + 1'b1;
          if (mcnt == 3'd5) begin
            state <= A_ADD;
          end
        end
        A_ADD: begin
          if (ovf) begin
            rerr <= 1'b1;
          end else begin
            for (int i = 0; i < hfit_pkg::NSUMS; i++) begin
              sums[i] <= sum_next[i][hfit_pkg::SW-1:0];
            end
          end
          done <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hfit_mac.sv
// Shift-add multiply-accumulate unit: wide operand times 64-bit signed operand.
module hfit_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          first,
  input  logic                          sub,
  input  logic signed [hfit_pkg::WW-1:0] a,
  input  logic signed [hfit_pkg::SW-1:0] b,
  output logic                          done,
  output logic signed [hfit_pkg::WW-1:0] acc
);

  localparam int CNTW = $clog2(hfit_pkg::SW);

  logic busy;
  logic [CNTW-1:0] cnt;
  logic [hfit_pkg::WW-1:0] a_sh;
  logic [hfit_pkg::SW-1:0] b_sh;
  logic sub_r;
  logic top_bit;

  assign top_bit = (cnt == CNTW'(hfit_pkg::SW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        a_sh <= a;
        b_sh <= b;
        sub_r <= sub;
        if (first) begin
          acc <= '0;
        end
      end else if (busy) begin
        if (b_sh[0]) begin
          if (sub_r ^ top_bit) begin
            acc <= acc - $signed(a_sh);
          end else begin
            acc <= acc + $signed(a_sh);
          end
        end
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt <= cnt + 1'b1;
        if (top_bit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/hfit_div.sv
// Restoring divider that rounds to nearest with ties away from zero.
module hfit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [hfit_pkg::WW-1:0] num,
  input  logic [hfit_pkg::WW-1:0]       den,
  output logic                          done,
  output logic signed [hfit_pkg::WW-1:0] q
);

  localparam int CNTW = $clog2(hfit_pkg::WW);

  logic busy;
  logic neg;
  logic [CNTW-1:0] cnt;
  logic [hfit_pkg::WW-1:0] dvd;
  logic [hfit_pkg::WW-1:0] dvs;
  logic [hfit_pkg::WW-1:0] rem;
  logic [hfit_pkg::WW-1:0] mag;
  logic [hfit_pkg::WW:0] rem_sh;
  logic fits;

  assign mag = num[hfit_pkg::WW-1] ? -num : num;
  assign rem_sh = {rem, dvd[hfit_pkg::WW-1]};
  assign fits = (rem_sh >= {1'b0, dvs});
  assign q = neg ? -$signed(dvd) : $signed(dvd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= num[hfit_pkg::WW-1];
        dvd <= (mag << 1) + den;
        dvs <= den << 1;
        rem <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= hfit_pkg::WW'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[hfit_pkg::WW-1:0];
        end
        dvd <= {dvd[hfit_pkg::WW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(hfit_pkg::WW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/helmert_four_param_fit_top.sv
// Top level of the four-parameter 2D Helmert least-squares fit.
// Input channel (in_valid/in_ready): one control pair per transfer, a source
// point and a target point in signed millimetres, with last_pair marking the
// final pair of a set. Output channel (out_valid/out_ready): one transfer per
// set, carrying the two offsets, the two scale terms and fit_status.
// After each pair transfer, in_ready stays low until the accumulator is done
// with that pair, so no new pair is taken before the last is through: one
// difference step, six passes through the 32 by 32 multiplier, one checked
// add of the seven sums and a return to idle, cut short by a range error.
// A pair with last_pair then runs the solve, unless a range error is flagged,
// on the 64-step shift-add multiply-accumulate unit and the 192-step
// divider.
// The result sits in an output register; while it waits for out_ready the
// block accepts and accumulates pairs of the next set, and a finished solve
// holds until that register is free.
// Reset clears the pair count, the sums, the error flag and both channels.
module helmert_four_param_fit_top #(
  parameter int MAX_PAIRS = 1024,
  parameter int SCALE_FRAC_BITS = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [35:0]  src_x,
  input  logic signed [35:0]  src_y,
  input  logic signed [35:0]  dst_x,
  input  logic signed [35:0]  dst_y,
  input  logic                last_pair,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [39:0]  offset_x,
  output logic signed [39:0]  offset_y,
  output logic signed [42:0]  scale_cos,
  output logic signed [42:0]  scale_sin,
  output logic [1:0]          fit_status
);

  localparam int CNTW = $clog2(MAX_PAIRS + 1);
  localparam int WW = hfit_pkg::WW;
  localparam int SW = hfit_pkg::SW;
  localparam int CW = hfit_pkg::CW;

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_ISSUE, S_MACW, S_DIVW, S_FIN} state_t;

  state_t state;
  logic [4:0] step;
  logic last_r;
  hfit_pkg::status_t status;
  logic signed [WW-1:0] d_r, nc_r, nd_r, ndn_r, tmp_r, t_r;
  logic signed [hfit_pkg::OFFW-1:0] res_ox, res_oy;
  logic signed [hfit_pkg::SCW-1:0] res_sc, res_ss;

  hfit_pkg::uop_t uop;
  hfit_pkg::acc_stat_t acc_stat;
  hfit_pkg::pair_t pair_in, origin;
  hfit_pkg::sum_arr_t sums;
  logic [CNTW-1:0] pair_count;
  logic acc_start, acc_clear, out_free;
  logic mac_start, mac_done, div_start, div_done;
  logic signed [WW-1:0] mac_a, mac_acc, div_q;
  logic signed [SW-1:0] mac_b;
  logic [WW-1:0] div_den;
  logic q_fits;

  assign uop = hfit_pkg::ucode(step);
  assign in_ready = (state == S_IDLE);
  assign acc_start = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign acc_clear = (state == S_FIN) && out_free;
  assign mac_start = (state == S_ISSUE) && (uop.kind == hfit_pkg::K_MAC);
  assign div_start = (state == S_ISSUE) && (uop.kind == hfit_pkg::K_DIV);
  assign pair_in = {dst_y, dst_x, src_y, src_x};

  always_comb begin
    case (uop.a)
      hfit_pkg::A_N:   mac_a = $signed(WW'(pair_count));
      hfit_pkg::A_SSU: mac_a = $signed({{(WW-SW){sums[0][SW-1]}}, sums[0]});
      hfit_pkg::A_SSV: mac_a = $signed({{(WW-SW){sums[1][SW-1]}}, sums[1]});
      hfit_pkg::A_D:   mac_a = d_r;
      hfit_pkg::A_NC:  mac_a = nc_r;
      hfit_pkg::A_ND:  mac_a = nd_r;
      hfit_pkg::A_TMP: mac_a = tmp_r;
      hfit_pkg::A_NDN: mac_a = ndn_r;
      default:         mac_a = '0;
    endcase
  end

  always_comb begin
    case (uop.b)
      hfit_pkg::B_N:     mac_b = $signed(SW'(pair_count));
      hfit_pkg::B_SSU:   mac_b = sums[0];
      hfit_pkg::B_SSV:   mac_b = sums[1];
      hfit_pkg::B_SSQ:   mac_b = sums[2];
      hfit_pkg::B_STU:   mac_b = sums[3];
      hfit_pkg::B_STV:   mac_b = sums[4];
      hfit_pkg::B_SP:    mac_b = sums[5];
      hfit_pkg::B_SQ:    mac_b = sums[6];
      hfit_pkg::B_OX:    mac_b = {{(SW-CW){origin[0][CW-1]}}, origin[0]};
      hfit_pkg::B_OY:    mac_b = {{(SW-CW){origin[1][CW-1]}}, origin[1]};
      hfit_pkg::B_OTX:   mac_b = {{(SW-CW){origin[2][CW-1]}}, origin[2]};
      hfit_pkg::B_OTY:   mac_b = {{(SW-CW){origin[3][CW-1]}}, origin[3]};
      hfit_pkg::B_SCALE: mac_b = $signed(SW'(1) << SCALE_FRAC_BITS);
      default:           mac_b = '0;
    endcase
  end

  assign div_den = (uop.den == hfit_pkg::DEN_NDN) ? ndn_r : d_r;

  always_comb begin
    if (uop.res == hfit_pkg::R_OX || uop.res == hfit_pkg::R_OY) begin
      q_fits = (&div_q[WW-1:hfit_pkg::OFFW-1]) || !(|div_q[WW-1:hfit_pkg::OFFW-1]);
    end else begin
      q_fits = (&div_q[WW-1:hfit_pkg::SCW-1]) || !(|div_q[WW-1:hfit_pkg::SCW-1]);
    end
  end

  hfit_accum #(.MAX_PAIRS(MAX_PAIRS)) u_accum (
    .clk(clk), .rst(rst), .start(acc_start), .clear(acc_clear), .pair(pair_in),
    .stat(acc_stat), .pair_count(pair_count), .sums(sums), .origin(origin)
  );

  hfit_mac u_mac (
    .clk(clk), .rst(rst), .start(mac_start), .first(uop.first), .sub(uop.sub),
    .a(mac_a), .b(mac_b), .done(mac_done), .acc(mac_acc)
  );

  hfit_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(t_r), .den(div_den),
    .done(div_done), .q(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      status <= hfit_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc_start) begin
            last_r <= last_pair;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_stat.done) begin
            step <= '0;
            status <= hfit_pkg::ST_OK;
            if (!last_r) begin
              state <= S_IDLE;
            end else if (acc_stat.range_err) begin
              status <= hfit_pkg::ST_RANGE;
              state <= S_FIN;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          unique case (uop.kind)
            hfit_pkg::K_MAC: state <= S_MACW;
            hfit_pkg::K_DIV: state <= S_DIVW;
            hfit_pkg::K_CHK: begin
              if (d_r[WW-1] || d_r == '0 || pair_count == '0) begin
                status <= hfit_pkg::ST_SINGULAR;
                state <= S_FIN;
              end else begin
                step <= step + 1'b1;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_MACW: begin
          if (mac_done) begin
            case (uop.dst)
              hfit_pkg::DST_D:   d_r <= mac_acc;
              hfit_pkg::DST_NC:  nc_r <= mac_acc;
              hfit_pkg::DST_ND:  nd_r <= mac_acc;
              hfit_pkg::DST_NDN: ndn_r <= mac_acc;
              hfit_pkg::DST_TMP: tmp_r <= mac_acc;
              hfit_pkg::DST_T:   t_r <= mac_acc;
              default: ;
            endcase
            step <= step + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (!q_fits) begin
              status <= hfit_pkg::ST_RANGE;
            end
            case (uop.res)
              hfit_pkg::R_OX: res_ox <= div_q[hfit_pkg::OFFW-1:0];
              hfit_pkg::R_OY: res_oy <= div_q[hfit_pkg::OFFW-1:0];
              hfit_pkg::R_SC: res_sc <= div_q[hfit_pkg::SCW-1:0];
              default:        res_ss <= div_q[hfit_pkg::SCW-1:0];
            endcase
            step <= step + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            fit_status <= status;
            if (status == hfit_pkg::ST_OK) begin
              offset_x <= res_ox;
              offset_y <= res_oy;
              scale_cos <= res_sc;
              scale_sin <= res_ss;
            end else begin
              offset_x <= '0;
              offset_y <= '0;
              scale_cos <= '0;
              scale_sin <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hfit_checker.sv
// Port-level checker of the Helmert fit block and its bind to the top level.
`include "helmert_four_param_fit_top_assert.svh"

module hfit_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [39:0] offset_x,
  input logic signed [39:0] offset_y,
  input logic signed [42:0] scale_cos,
  input logic signed [42:0] scale_sin,
  input logic [1:0]         fit_status
);

  `HFIT_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `HFIT_ASSERT_NOW(a_status_code, out_valid, fit_status <= hfit_pkg::ST_RANGE)
  `HFIT_ASSERT_NOW(a_zero_on_error, out_valid && fit_status != hfit_pkg::ST_OK,
    offset_x == '0 && offset_y == '0 && scale_cos == '0 && scale_sin == '0)
  `HFIT_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
    out_valid && $stable(fit_status) && $stable(offset_x) && $stable(scale_cos))

endmodule

bind helmert_four_param_fit_top hfit_checker u_hfit_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .offset_x(offset_x),
  .offset_y(offset_y), .scale_cos(scale_cos), .scale_sin(scale_sin),
  .fit_status(fit_status)
);
